// ===== hdl/positional_ordered_list_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positional ordered list unit
// Shared clocking and reset gating for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define POL_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define POL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// pol_pkg
// Types and constants shared by the positional ordered list unit.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int VAL_W  = 32;
  localparam int POS_W  = 9;
  localparam int LEN_W  = 9;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  localparam int DEFAULT_CAPACITY = 256;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_INS_AT   = 3'd2,
    REQ_DEL_HEAD = 3'd3,
    REQ_DEL_TAIL = 3'd4,
    REQ_DEL_AT   = 3'd5,
    REQ_READ_AT  = 3'd6
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BEYOND = 2'd3
  } status_e;

  // What every cell does in a given cycle
  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_INS  = 3'd1,
    CELL_DEL  = 3'd2,
    CELL_ROTL = 3'd3,
    CELL_ROTR = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [VAL_W-1:0]  value;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_SEEK   = 2'd1,
    FSM_RETURN = 2'd2,
    FSM_DROP   = 2'd3
  } fsm_e;

endpackage

// ===== hdl/pol_cell.sv =====
// ----------------------------------------------------------------------------
// pol_cell
// One list slot: holds a value and takes it from a neighbor or the input.
// ----------------------------------------------------------------------------
module pol_cell import pol_pkg::*; #(
  parameter int  CAPACITY = DEFAULT_CAPACITY,
  parameter int  IDX      = 0,
  localparam int IW       = $clog2(CAPACITY)
) (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [IW-1:0]    idx_i,
  input  logic [VAL_W-1:0] left_i,
  input  logic [VAL_W-1:0] right_i,
  output logic [VAL_W-1:0] val_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [VAL_W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      CELL_INS: begin
        if (MY_IDX == idx_i) begin
          val_d = ctl_i.value;
        end else if (MY_IDX > idx_i) begin
          val_d = left_i;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= idx_i) begin
          val_d = right_i;
        end
      end
      CELL_ROTL: val_d = right_i;
      CELL_ROTR: val_d = left_i;
      default:   val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== hdl/pol_ctrl.sv =====
// ----------------------------------------------------------------------------
// pol_ctrl
// Request decode, length counter, ring seek sequencer and result register.
// ----------------------------------------------------------------------------
`include "positional_ordered_list_unit_assert.svh"

module pol_ctrl import pol_pkg::*; #(
  parameter int  CAPACITY = DEFAULT_CAPACITY,
  localparam int IW       = $clog2(CAPACITY),
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [POS_W-1:0]        position_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [STAT_W-1:0]       status_o,
  output logic signed [VAL_W-1:0] data_out_o,
  output logic [LEN_W-1:0]        length_o,
  input  logic [VAL_W-1:0]        head_val_i,
  output cell_ctl_t               cell_ctl_o,
  output logic [IW-1:0]           cell_idx_o
);

  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  fsm_e            state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [IW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   steps_q, steps_d;
  logic            del_q, del_d;

  logic            rsp_valid_q;
  status_e         rsp_status_q;
  logic [VAL_W-1:0] rsp_data_q;
  logic [LEN_W-1:0] rsp_len_q;

  logic             load;
  status_e          ld_status;
  logic [VAL_W-1:0] ld_data;
  logic [LEN_W-1:0] ld_len;

  // decode
  logic             accept;
  logic [POS_W-1:0] kidx;
  logic [CMP_W-1:0] k_ext, c_ext;
  logic             full, empty;
  logic             is_ins, is_sel, is_del, chk_k;
  logic             ins_ok, sel_ok, seek;
  status_e          dec_status;
  logic [IW-1:0]    pos_idx;

  assign in_ready_o = (state_q == FSM_IDLE) && (!rsp_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    kidx    = (position_i <= POS_W'(1)) ? '0 : position_i - 1'b1;
    k_ext   = CMP_W'(kidx);
    c_ext   = CMP_W'(count_q);
    full    = (count_q == CW'(CAPACITY));
    empty   = (count_q == '0);
    is_ins  = 1'b0;
    is_sel  = 1'b0;
    is_del  = 1'b0;
    chk_k   = 1'b0;
    pos_idx = '0;
    case (req_e'(req_type_i))
      REQ_INS_HEAD: is_ins = 1'b1;
      REQ_INS_TAIL: begin
        is_ins  = 1'b1;
        pos_idx = IW'(count_q);
      end
      REQ_INS_AT: begin
        is_ins  = 1'b1;
        pos_idx = (k_ext > c_ext) ? IW'(count_q) : IW'(kidx);
      end
      REQ_DEL_HEAD: begin
        is_sel = 1'b1;
        is_del = 1'b1;
      end
      REQ_DEL_TAIL: begin
        is_sel  = 1'b1;
        is_del  = 1'b1;
        pos_idx = IW'(count_q - 1'b1);
      end
      REQ_DEL_AT: begin
        is_sel  = 1'b1;
        is_del  = 1'b1;
        chk_k   = 1'b1;
        pos_idx = IW'(kidx);
      end
      REQ_READ_AT: begin
        is_sel  = 1'b1;
        chk_k   = 1'b1;
        pos_idx = IW'(kidx);
      end
      default: ;
    endcase

    ins_ok     = is_ins && !full;
    sel_ok     = is_sel && !empty && !(chk_k && (k_ext >= c_ext));
    dec_status = ST_DONE;
    if (is_ins && full) begin
      dec_status = ST_FULL;
    end else if (is_sel && empty) begin
      dec_status = ST_EMPTY;
    end else if (is_sel && !sel_ok) begin
      dec_status = ST_BEYOND;
    end
    seek = accept && sel_ok && (pos_idx != '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (seek) begin
          state_d = FSM_SEEK;
        end
      end
      FSM_SEEK: begin
        if (cnt_q == IW'(1)) begin
          state_d = FSM_RETURN;
        end
      end
      FSM_RETURN: begin
        if (cnt_q == IW'(1)) begin
          state_d = del_q ? FSM_DROP : FSM_IDLE;
        end
      end
      FSM_DROP: state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cell_ctl_o.op    = CELL_HOLD;
    cell_ctl_o.value = value_i;
    cell_idx_o       = pos_idx;
    count_d          = count_q;
    cnt_d            = cnt_q;
    steps_d          = steps_q;
    del_d            = del_q;
    load             = 1'b0;
    ld_status        = dec_status;
    ld_data          = '0;
    ld_len           = LEN_W'(count_q);
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          if (ins_ok) begin
            cell_ctl_o.op = CELL_INS;
            count_d       = count_q + 1'b1;
            load          = 1'b1;
            ld_len        = LEN_W'(count_q + 1'b1);
          end else if (sel_ok && (pos_idx == '0)) begin
            // head is a fixed tap: serve it in this cycle
            load    = 1'b1;
            ld_data = head_val_i;
            if (is_del) begin
              cell_ctl_o.op = CELL_DEL;
              count_d       = count_q - 1'b1;
              ld_len        = LEN_W'(count_q - 1'b1);
            end
          end else if (sel_ok) begin
            cnt_d   = pos_idx;
            steps_d = pos_idx;
            del_d   = is_del;
          end else begin
            load = 1'b1;
          end
        end
      end
      FSM_SEEK: begin
        cell_ctl_o.op = CELL_ROTL;
        cnt_d         = (cnt_q == IW'(1)) ? steps_q : cnt_q - 1'b1;
      end
      FSM_RETURN: begin
        cell_ctl_o.op = CELL_ROTR;
        cnt_d         = cnt_q - 1'b1;
        // the wanted entry sits at the head on the first return cycle
        if (cnt_q == steps_q) begin
          load      = 1'b1;
          ld_status = ST_DONE;
          ld_data   = head_val_i;
          ld_len    = del_q ? LEN_W'(count_q - 1'b1) : LEN_W'(count_q);
        end
      end
      FSM_DROP: begin
        cell_ctl_o.op = CELL_DEL;
        cell_idx_o    = steps_q;
        count_d       = count_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      cnt_q       <= '0;
      steps_q     <= '0;
      del_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      steps_q <= steps_d;
      del_q   <= del_d;
      if (load) begin
        rsp_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_status_q <= ld_status;
      rsp_data_q   <= ld_data;
      rsp_len_q    <= ld_len;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign status_o    = rsp_status_q;
  assign data_out_o  = rsp_data_q;
  assign length_o    = rsp_len_q;

  `POL_ASSERT_NOW(a_count_bound, count_q <= CW'(CAPACITY), "list length above capacity")
  `POL_ASSERT_NEXT(a_ins_grows, cell_ctl_o.op == CELL_INS, count_q == $past(count_q) + 1'b1, "insert did not grow the list")
  `POL_ASSERT_NEXT(a_rot_keeps, cell_ctl_o.op == CELL_ROTL || cell_ctl_o.op == CELL_ROTR, count_q == $past(count_q), "rotation changed the length")
  `POL_ASSERT_NOW(a_cnt_live, state_q == FSM_IDLE || state_q == FSM_DROP || cnt_q != '0, "seek counter ran out mid sequence")
  `POL_ASSERT_NOW(a_seek_no_rsp, state_q != FSM_SEEK || !rsp_valid_q, "result pending during seek")

endmodule

// ===== hdl/positional_ordered_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list_unit
// Bounded ordered list of signed 32-bit values held in a ring of cells.
// ----------------------------------------------------------------------------
// One request per transaction, one result per request. Inserts of any kind
// and deletes or reads that land on the head need no seek: for an insert or
// delete every cell compares its index with the target and shifts in the same
// clock. A read or delete at position k > 1 (delete tail uses k = length)
// runs the seek sequencer: the ring of cells rotates the wanted entry to the
// head tap, rotates back, and a delete then closes the gap. A new request is
// taken once the sequencer is idle and the result register is free or being
// drained. No clearing pass after reset.
module positional_ordered_list_unit import pol_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [POS_W-1:0]        position_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [STAT_W-1:0]       status_o,
  output logic signed [VAL_W-1:0] data_out_o,
  output logic [LEN_W-1:0]        length_o
);

  localparam int IW = $clog2(CAPACITY);

  cell_ctl_t        cell_ctl;
  logic [IW-1:0]    cell_idx;
  logic [VAL_W-1:0] cell_val [CAPACITY];

  pol_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .length_o    (length_o),
    .head_val_i  (cell_val[0]),
    .cell_ctl_o  (cell_ctl),
    .cell_idx_o  (cell_idx)
  );

  // ring: last cell wraps to the head for rotation
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? CAPACITY - 1 : i - 1;
    localparam int RIGHT = (i == CAPACITY - 1) ? 0 : i + 1;

    pol_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .idx_i   (cell_idx),
      .left_i  (cell_val[LEFT]),
      .right_i (cell_val[RIGHT]),
      .val_o   (cell_val[i])
    );
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the positional ordered list unit.
// ----------------------------------------------------------------------------
// Requests go in one transaction at a time. A queue mirrors the list contents
// and yields the expected status, data and length for every accepted request.
// A checker compares each result against the oldest prediction. Directed
// corner cases come first. Random traffic follows with three idle profiles
// and a long receiver hold-off. The run ends with a fill to capacity and a
// full drain.
// ----------------------------------------------------------------------------
module tb_top import pol_pkg::*; ();

  localparam int LIST_CAP = DEFAULT_CAPACITY;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * LIST_CAP + 64;

  typedef struct {
    status_e                 status;
    logic signed [VAL_W-1:0] data;
    logic [LEN_W-1:0]        length;
  } list_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [REQ_W-1:0]        req_type_i = '0;
  logic signed [VAL_W-1:0] value_i = '0;
  logic [POS_W-1:0]        position_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [STAT_W-1:0]       status_o;
  logic signed [VAL_W-1:0] data_out_o;
  logic [LEN_W-1:0]        length_o;

  logic signed [VAL_W-1:0] list_image[$];
  list_result_t            pending_results[$];
  int                      mismatch_count = 0;
  int                      src_idle_pct = 0;
  int                      snk_idle_pct = 0;
  int                      hold_req = 0;
  int                      hold_taken = 0;
  int                      hold_left = 0;

  positional_ordered_list_unit #(.CAPACITY(LIST_CAP)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .length_o    (length_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- list model
  function automatic status_e model_insert(int idx, logic signed [VAL_W-1:0] val);
    if (list_image.size() >= LIST_CAP) return ST_FULL;
    if (idx >= list_image.size()) list_image.push_back(val);
    else list_image.insert(idx, val);
    return ST_DONE;
  endfunction

  function automatic status_e model_delete(int idx, output logic signed [VAL_W-1:0] removed);
    removed = '0;
    if (list_image.size() == 0) return ST_EMPTY;
    if (idx >= list_image.size()) return ST_BEYOND;
    removed = list_image[idx];
    list_image.delete(idx);
    return ST_DONE;
  endfunction

  function automatic list_result_t predict_list_op(logic [REQ_W-1:0] req,
                                                   logic signed [VAL_W-1:0] val,
                                                   logic [POS_W-1:0] pos);
    list_result_t            res;
    logic signed [VAL_W-1:0] removed;
    int                      kidx;
    int                      n;
    kidx = (pos <= 1) ? 0 : int'(pos) - 1;
    n = list_image.size();
    res.status = ST_DONE;
    res.data = '0;
    removed = '0;
    case (req)
      REQ_INS_HEAD: res.status = model_insert(0, val);
      REQ_INS_TAIL: res.status = model_insert(n, val);
      REQ_INS_AT:   res.status = model_insert(kidx, val);
      REQ_DEL_HEAD: res.status = model_delete(0, removed);
      REQ_DEL_TAIL: begin
        if (n == 0) res.status = ST_EMPTY;
        else res.status = model_delete(n - 1, removed);
      end
      REQ_DEL_AT:   res.status = model_delete(kidx, removed);
      REQ_READ_AT: begin
        if (n == 0) res.status = ST_EMPTY;
        else if (kidx >= n) res.status = ST_BEYOND;
        else removed = list_image[kidx];
      end
      default: ;
    endcase
    res.data = removed;
    res.length = LEN_W'(list_image.size());
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(15))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly positions inside or just past the list, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_position(int n);
    if ($urandom_range(99) < 80) return POS_W'($urandom_range(n + 2, 0));
    return POS_W'($urandom_range(511, 0));
  endfunction

  function automatic logic [REQ_W-1:0] pick_insert();
    case ($urandom_range(2))
      0: return REQ_INS_HEAD;
      1: return REQ_INS_TAIL;
      default: return REQ_INS_AT;
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_delete();
    case ($urandom_range(2))
      0: return REQ_DEL_HEAD;
      1: return REQ_DEL_TAIL;
      default: return REQ_DEL_AT;
    endcase
  endfunction

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_request(logic [REQ_W-1:0] req, logic signed [VAL_W-1:0] val,
                              logic [POS_W-1:0] pos);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    position_i <= pos;
    do @(negedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_list_op(req, val, pos));
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk_i) begin
    if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("tb_top: mismatch: %s", msg);
  endtask

  always @(negedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d data %0d len %0d",
                                  status_o, data_out_o, length_o));
      end else begin
        exp_res = pending_results.pop_front();
        if (status_o !== exp_res.status)
          report_mismatch($sformatf("status exp %0d got %0d", exp_res.status, status_o));
        if (data_out_o !== exp_res.data)
          report_mismatch($sformatf("data_out exp %0d got %0d", exp_res.data, data_out_o));
        if (length_o !== exp_res.length)
          report_mismatch($sformatf("length exp %0d got %0d", exp_res.length, length_o));
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_request(REQ_READ_AT,  '0, 9'd0);
    send_request(REQ_DEL_HEAD, '0, 9'd0);
    send_request(REQ_DEL_TAIL, '0, 9'd0);
    send_request(REQ_DEL_AT,   '0, 9'd3);
    send_request(REQ_INS_AT,   32'sh7FFF_FFFF, 9'd5);   // into empty list
    send_request(REQ_INS_HEAD, 32'sh8000_0000, 9'd0);
    send_request(REQ_INS_TAIL, '0, 9'd0);
    send_request(REQ_INS_AT,   '1, 9'd0);
    send_request(REQ_INS_AT,   32'sh0000_0001, 9'd1);
    send_request(REQ_INS_AT,   32'sh5A5A_5A5A, 9'd5);   // k == length: before tail
    send_request(REQ_INS_AT,   32'shA5A5_A5A5, 9'd511); // past end: append
    send_request(REQ_READ_AT,  '0, 9'd0);
    send_request(REQ_READ_AT,  '0, 9'd1);
    send_request(REQ_READ_AT,  '0, 9'd7);
    send_request(REQ_READ_AT,  '0, 9'd8);
    send_request(REQ_READ_AT,  '0, 9'd511);
    send_request(REQ_UNUSED,   '1, 9'd511);
    send_request(REQ_DEL_AT,   '0, 9'd511);
    send_request(REQ_DEL_AT,   '0, 9'd0);
    send_request(REQ_DEL_AT,   '0, 9'd1);
    send_request(REQ_DEL_AT,   '0, 9'd3);
    send_request(REQ_DEL_AT,   '0, 9'd4);
    send_request(REQ_DEL_TAIL, '0, 9'd0);
    send_request(REQ_DEL_HEAD, '0, 9'd0);
    send_request(REQ_DEL_HEAD, '0, 9'd0);
    send_request(REQ_UNUSED,   '0, 9'd0);
  endtask

  // Random mix; the insert share drops once the list passes soft_len so
  // deletes and reads stay cheap.
  task automatic test_mixed(int num_items, int soft_len);
    int               roll;
    int               ins_share;
    logic [REQ_W-1:0] req;
    for (int i = 0; i < num_items; i++) begin
      roll = $urandom_range(99);
      ins_share = (list_image.size() < soft_len) ? 45 : 25;
      if (roll < 3) req = REQ_UNUSED;
      else if (roll < 22) req = REQ_READ_AT;
      else if (roll < 22 + ins_share) req = pick_insert();
      else req = pick_delete();
      send_request(req, rand_value(), pick_position(list_image.size()));
    end
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    hold_req = hold_req + 1;
    @(posedge clk_i);
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_request(REQ_READ_AT, rand_value(), pick_position(list_image.size()));
      else send_request(pick_insert(), rand_value(), pick_position(list_image.size()));
    end
  endtask

  task automatic test_fill_and_drain();
    while (list_image.size() < LIST_CAP)
      send_request(pick_insert(), rand_value(), pick_position(list_image.size()));
    // list full: every insert kind is dropped
    for (int i = 0; i < 3; i++) begin
      send_request(REQ_INS_HEAD, rand_value(), 9'd0);
      send_request(REQ_INS_TAIL, rand_value(), 9'd511);
      send_request(REQ_INS_AT, rand_value(), POS_W'($urandom_range(511)));
    end
    send_request(REQ_READ_AT, '0, 9'd1);
    send_request(REQ_READ_AT, '0, POS_W'(LIST_CAP));
    send_request(REQ_READ_AT, '0, POS_W'(LIST_CAP + 1));
    send_request(REQ_DEL_AT, '0, 9'd511);
    send_request(REQ_DEL_AT, '0, POS_W'(LIST_CAP));
    send_request(REQ_INS_AT, rand_value(), POS_W'(LIST_CAP - 1));
    while (list_image.size() > 0) begin
      if ($urandom_range(9) == 0)
        send_request(REQ_READ_AT, '0, pick_position(list_image.size()));
      else
        send_request(pick_delete(), rand_value(), pick_position(list_image.size()));
    end
    send_request(REQ_DEL_TAIL, '0, 9'd0);
    send_request(REQ_READ_AT, '0, 9'd1);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 20;
    snk_idle_pct = 58;
    test_directed();
    test_mixed(60, 24);

    src_idle_pct = 58;
    snk_idle_pct = 20;
    test_mixed(60, 16);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_backpressure();
    test_mixed(40, 40);
    test_fill_and_drain();
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== positional_ordered_list_unit.f =====
+incdir+hdl
hdl/pol_pkg.sv
hdl/pol_cell.sv
hdl/pol_ctrl.sv
hdl/positional_ordered_list_unit.sv
bench/tb_top.sv
